### hdl/i2cs_pkg.sv
// Shared types, codes and helper functions of the I2C slave command front end.
package i2cs_pkg;

    localparam int DEF_BUF_BYTES   = 6;
    localparam int DEF_NUM_BUFFERS = 6;

    localparam logic [2:0] NO_BUFFER = 3'd6;
    localparam int         SHORT_LEN = 4;

    // order byte classes
    localparam logic [7:0] CLASS_MASK  = 8'hC0;
    localparam logic [7:0] CLASS_WRITE = 8'h40;
    localparam logic [7:0] CLASS_READ  = 8'h80;

    // order codes
    localparam logic [7:0] ORD_POWER   = 8'h41;
    localparam logic [7:0] ORD_SENSOR  = 8'h46;
    localparam logic [7:0] ORD_BUTTON  = 8'h82;
    localparam logic [7:0] ORD_ACC     = 8'h83;
    localparam logic [7:0] ORD_GYRO    = 8'h84;
    localparam logic [7:0] ORD_MAGN    = 8'h85;
    localparam logic [7:0] ORD_PWR     = 8'h8A;
    localparam logic [7:0] ORD_VOUT    = 8'h8B;
    localparam logic [7:0] ORD_BATT    = 8'h8C;

    localparam logic CMD_POWER  = 1'b0;
    localparam logic CMD_SENSOR = 1'b1;

    typedef enum logic [2:0] {
        OP_ADDR_WR    = 3'd0,
        OP_BYTE_RX    = 3'd1,
        OP_ADDR_RD    = 3'd2,
        OP_BYTE_ACK   = 3'd3,
        OP_OTHER      = 3'd4,
        OP_LOAD       = 3'd5,
        OP_SET_BUTTON = 3'd6,
        OP_SET_BANK   = 3'd7
    } t_opcode;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] byte_in;
        logic [2:0] buffer_id;
        logic       bank;
        logic [2:0] offset;
    } t_in_item;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       cmd_valid;
        logic       cmd_kind;
        logic [7:0] cmd_data;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_FETCH = 2'd1,
        S_HOLD  = 2'd2
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic exec;   // apply the accepted word
        logic fetch;  // move buffer read data into the output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic needs_read;  // current input word takes a byte from the store
    } t_dp_status;

    // sensor buffer selected by a read class order, NO_BUFFER if none
    function automatic logic [2:0] order_to_buffer(input logic [7:0] order);
        logic [2:0] sel;
        sel = NO_BUFFER;
        case (order)
            ORD_ACC:  sel = 3'd0;
            ORD_GYRO: sel = 3'd1;
            ORD_MAGN: sel = 3'd2;
            ORD_PWR:  sel = 3'd3;
            ORD_VOUT: sel = 3'd4;
            ORD_BATT: sel = 3'd5;
            default:  sel = NO_BUFFER;
        endcase
        return sel;
    endfunction

    function automatic int buf_len(input logic [2:0] id, input int buf_bytes);
        int n;
        n = (id < 3'd3) ? buf_bytes : SHORT_LEN;
        return (n < buf_bytes) ? n : buf_bytes;
    endfunction

endpackage

### hdl/i2cs_ctrl.sv
// Sequencing of one bus event word: accept, optional store read, result hold.
module i2cs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  i2cs_pkg::t_dp_status  i_status,
    output i2cs_pkg::t_dp_cmd     o_cmd
);
    import i2cs_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_out_valid = 1'b0;
        o_in_stall  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
            end
            S_FETCH: begin
                n_state = S_HOLD;
            end
            S_HOLD: begin
                o_out_valid = 1'b1;
                // a new word may enter in the cycle the result leaves
                o_in_stall  = i_out_stall;
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        w_accept = i_in_valid && !o_in_stall;
        if (w_accept) begin
            n_state = i_status.needs_read ? S_FETCH : S_HOLD;
        end
        o_cmd.exec  = w_accept;
        o_cmd.fetch = (r_state == S_FETCH);
    end

`ifndef SYNTHESIS
    a_fetch_then_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FETCH |=> r_state == S_HOLD)
        else $error("fetch not followed by hold");

    a_no_accept_in_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FETCH |-> o_in_stall)
        else $error("word accepted during store read");

    a_direct_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !i_status.needs_read |=> o_out_valid)
        else $error("result missing after register-only word");

    a_read_delays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_status.needs_read |=> !o_out_valid)
        else $error("result shown before store read data");
`endif

endmodule

### hdl/i2cs_datapath.sv
// Order register, banked sensor store, read pointer and result register.
module i2cs_datapath #(
    parameter int BUF_BYTES   = i2cs_pkg::DEF_BUF_BYTES,
    parameter int NUM_BUFFERS = i2cs_pkg::DEF_NUM_BUFFERS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  i2cs_pkg::t_in_item    i_item,
    input  i2cs_pkg::t_dp_cmd     i_cmd,
    output i2cs_pkg::t_dp_status  o_status,
    output i2cs_pkg::t_out_item   o_item
);
    import i2cs_pkg::*;

    localparam int DEPTH = NUM_BUFFERS * 2 * BUF_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(BUF_BYTES + 1);
    localparam int IW    = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;

    logic [7:0]             r_mem [DEPTH];
    logic [DEPTH-1:0]       r_ent_vld;
    logic [7:0]             r_rd_data;
    logic                   r_rd_ok;

    logic [7:0]             r_order,   n_order;
    logic [NUM_BUFFERS-1:0] r_bank_ch, n_bank_ch;
    logic [7:0]             r_button,  n_button;
    logic [2:0]             r_act,     n_act;
    logic                   r_act_bank, n_act_bank;
    logic [PW-1:0]          r_ptr,     n_ptr;
    t_out_item              r_out,     n_out;

    t_opcode    w_op;
    logic [2:0] w_sel;
    logic       w_sel_ok;
    logic       w_sel_bank;
    logic       w_act_ok;
    logic       w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic       w_wr_en;
    logic [AW-1:0] w_wr_addr;

    always_comb begin
        w_op       = t_opcode'(i_item.opcode);
        n_order    = r_order;
        n_bank_ch  = r_bank_ch;
        n_button   = r_button;
        n_act      = r_act;
        n_act_bank = r_act_bank;
        n_ptr      = r_ptr;
        n_out      = '0;
        w_rd_en    = 1'b0;
        w_rd_addr  = '0;
        w_wr_en    = 1'b0;
        w_wr_addr  = AW'(((int'(i_item.buffer_id) * 2 + int'(i_item.bank)) * BUF_BYTES)
                         + int'(i_item.offset));

        w_sel = ((r_order & CLASS_MASK) == CLASS_READ) ? order_to_buffer(r_order)
                                                       : NO_BUFFER;
        w_sel_ok   = (w_sel != NO_BUFFER) && (int'(w_sel) < NUM_BUFFERS);
        w_sel_bank = r_bank_ch[w_sel[IW-1:0]];
        w_act_ok   = (r_act != NO_BUFFER) && (int'(r_act) < NUM_BUFFERS)
                     && (int'(r_ptr) < buf_len(r_act, BUF_BYTES));

        unique case (w_op)
            OP_BYTE_RX: begin
                if ((r_order & CLASS_MASK) == CLASS_WRITE) begin
                    if (r_order == ORD_POWER) begin
                        n_out.cmd_valid = 1'b1;
                        n_out.cmd_kind  = CMD_POWER;
                        n_out.cmd_data  = i_item.byte_in;
                    end else if (r_order == ORD_SENSOR) begin
                        n_out.cmd_valid = 1'b1;
                        n_out.cmd_kind  = CMD_SENSOR;
                        n_out.cmd_data  = i_item.byte_in;
                    end
                    n_order = '0;
                end else begin
                    n_order = i_item.byte_in;
                end
            end
            OP_ADDR_RD: begin
                n_out.tx_valid = 1'b1;
                n_act          = NO_BUFFER;
                n_ptr          = '0;
                if (r_order == ORD_BUTTON) begin
                    n_out.tx_byte = r_button;
                end
                if (w_sel_ok) begin
                    n_act      = w_sel;
                    n_act_bank = w_sel_bank;
                    n_ptr      = PW'(1);
                    w_rd_en    = 1'b1;
                    w_rd_addr  = AW'((int'(w_sel) * 2 + int'(w_sel_bank)) * BUF_BYTES);
                end
            end
            OP_BYTE_ACK: begin
                n_out.tx_valid = 1'b1;
                if (w_act_ok) begin
                    n_ptr     = r_ptr + 1'b1;
                    w_rd_en   = 1'b1;
                    w_rd_addr = AW'(((int'(r_act) * 2 + int'(r_act_bank)) * BUF_BYTES)
                                    + int'(r_ptr));
                end
            end
            OP_LOAD: begin
                w_wr_en = (int'(i_item.buffer_id) < NUM_BUFFERS)
                          && (int'(i_item.offset) < BUF_BYTES);
            end
            OP_SET_BUTTON: begin
                n_button = i_item.byte_in;
            end
            OP_SET_BANK: begin
                if (int'(i_item.buffer_id) < NUM_BUFFERS) begin
                    n_bank_ch[i_item.buffer_id[IW-1:0]] = i_item.bank;
                end
            end
            default: begin
            end
        endcase

        o_status.needs_read = w_rd_en;
    end

    // sensor store: one write or one read per word, read data registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_wr_en) begin
            r_mem[w_wr_addr] <= i_item.byte_in;
        end
        if (i_cmd.exec && w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // entries never loaded since reset read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
            r_rd_ok   <= 1'b0;
        end else if (i_cmd.exec) begin
            if (w_wr_en) begin
                r_ent_vld[w_wr_addr] <= 1'b1;
            end
            if (w_rd_en) begin
                r_rd_ok <= r_ent_vld[w_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order    <= '0;
            r_bank_ch  <= '0;
            r_button   <= '0;
            r_act      <= NO_BUFFER;
            r_act_bank <= 1'b0;
            r_ptr      <= '0;
        end else if (i_cmd.exec) begin
            r_order    <= n_order;
            r_bank_ch  <= n_bank_ch;
            r_button   <= n_button;
            r_act      <= n_act;
            r_act_bank <= n_act_bank;
            r_ptr      <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out <= n_out;
        end else if (i_cmd.fetch) begin
            r_out.tx_byte <= r_rd_ok ? r_rd_data : 8'h00;
        end
    end

    assign o_item = r_out;

endmodule

### hdl/i2c_slave_command_register_map_core.sv
// Top level of the I2C slave command front end: controller plus datapath.
//
// One bus event word in, exactly one result word out. A word that sends a
// sensor buffer byte (read address match on a sensor order, or an acked byte
// still inside the active buffer) reads the banked sensor store, whose read
// data is registered, so its result passes through the FETCH state into HOLD;
// every other word shows its result in the cycle after acceptance. The next
// word is accepted in the cycle the previous result is taken, so with no stall
// the block runs one word every cycle, but none is taken during FETCH.
// Store entries that were never loaded read as zero; no clearing pass is needed.
module i2c_slave_command_register_map_core #(
    parameter int BUF_BYTES   = i2cs_pkg::DEF_BUF_BYTES,
    parameter int NUM_BUFFERS = i2cs_pkg::DEF_NUM_BUFFERS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  i2cs_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output i2cs_pkg::t_out_item  o_out_item
);
    import i2cs_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    i2cs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    i2cs_datapath #(
        .BUF_BYTES   (BUF_BYTES),
        .NUM_BUFFERS (NUM_BUFFERS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_in_item),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_item   (o_out_item)
    );

endmodule

### dv/i2c_slave_command_register_map_core_test.sv
// Testbench for the I2C slave command front end: directed bus events, random traffic, checking.
`timescale 1ns / 100ps

module i2c_slave_command_register_map_core_test;
    import i2cs_pkg::*;

    localparam int BUF_LEN   = DEF_BUF_BYTES;
    localparam int NUM_BUF   = DEF_NUM_BUFFERS;
    localparam int LIMIT     = 200000;
    localparam int MAX_LINES = 50;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    i2c_slave_command_register_map_core #(
        .BUF_BYTES  (BUF_LEN),
        .NUM_BUFFERS(NUM_BUF)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    // shadow state of the slave front end
    logic [7:0] order_q;
    logic [7:0] sensor_mem [NUM_BUF][2][BUF_LEN];
    logic       bank_sel [NUM_BUF];
    logic [7:0] button_q;
    logic [2:0] act_buf;
    logic       act_bank;
    logic [2:0] rd_ptr;

    t_out_item bus_reply_q[$];
    t_out_item want_reply;
    int        mismatch_count;
    int        events_sent;
    int        cycle_count;
    int        stall_left;
    bit        idling_on;

    always #4 i_clk = ~i_clk;

    // next byte of the active buffer, zero past its end or with none active
    function automatic logic [7:0] pop_store_byte();
        int len;
        logic [7:0] v;
        if (act_buf == NO_BUFFER || act_buf >= NUM_BUF) return 8'h00;
        len = (act_buf < 3) ? BUF_LEN : SHORT_LEN;
        if (len > BUF_LEN) len = BUF_LEN;
        if (rd_ptr >= len) return 8'h00;
        v = sensor_mem[act_buf][act_bank][rd_ptr];
        rd_ptr = rd_ptr + 3'd1;
        return v;
    endfunction

    function automatic t_out_item predict_reply(input t_in_item w);
        t_out_item r;
        logic [2:0] sel;
        r = '0;
        sel = NO_BUFFER;
        case (w.opcode)
            OP_BYTE_RX: begin
                if ((order_q & CLASS_MASK) == CLASS_WRITE) begin
                    if (order_q == ORD_POWER) begin
                        r.cmd_valid = 1'b1;
                        r.cmd_kind  = CMD_POWER;
                        r.cmd_data  = w.byte_in;
                    end else if (order_q == ORD_SENSOR) begin
                        r.cmd_valid = 1'b1;
                        r.cmd_kind  = CMD_SENSOR;
                        r.cmd_data  = w.byte_in;
                    end
                    order_q = 8'h00;
                end else begin
                    order_q = w.byte_in;
                end
            end
            OP_ADDR_RD: begin
                r.tx_valid = 1'b1;
                act_buf = NO_BUFFER;
                rd_ptr = '0;
                if ((order_q & CLASS_MASK) == CLASS_READ) begin
                    case (order_q)
                        ORD_BUTTON: r.tx_byte = button_q;
                        ORD_ACC:    sel = 3'd0;
                        ORD_GYRO:   sel = 3'd1;
                        ORD_MAGN:   sel = 3'd2;
                        ORD_PWR:    sel = 3'd3;
                        ORD_VOUT:   sel = 3'd4;
                        ORD_BATT:   sel = 3'd5;
                        default:    sel = NO_BUFFER;
                    endcase
                end
                if (sel != NO_BUFFER && sel < NUM_BUF) begin
                    act_buf = sel;
                    act_bank = bank_sel[sel];
                    r.tx_byte = pop_store_byte();
                end
            end
            OP_BYTE_ACK: begin
                r.tx_valid = 1'b1;
                r.tx_byte  = pop_store_byte();
            end
            OP_LOAD: begin
                if (w.buffer_id < NUM_BUF && w.offset < BUF_LEN)
                    sensor_mem[w.buffer_id][w.bank][w.offset] = w.byte_in;
            end
            OP_SET_BUTTON: button_q = w.byte_in;
            OP_SET_BANK: begin
                if (w.buffer_id < NUM_BUF) bank_sel[w.buffer_id] = w.bank;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_in_item pack_event(input t_opcode op, input logic [7:0] b,
                                            input logic [2:0] id, input logic bk,
                                            input logic [2:0] off);
        t_in_item w;
        w.opcode    = op;
        w.byte_in   = b;
        w.buffer_id = id;
        w.bank      = bk;
        w.offset    = off;
        return w;
    endfunction

    function automatic t_in_item rand_event(input t_opcode op);
        return pack_event(op, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                          1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
    endfunction

    function automatic logic [7:0] pick_read_order();
        case ($urandom_range(0, 8))
            0:       return ORD_BUTTON;
            1:       return ORD_ACC;
            2:       return ORD_GYRO;
            3:       return ORD_MAGN;
            4:       return ORD_PWR;
            5:       return ORD_VOUT;
            6:       return ORD_BATT;
            7:       return CLASS_READ | 8'($urandom_range(0, 63));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_write_order();
        case ($urandom_range(0, 4))
            0, 1:    return ORD_POWER;
            2, 3:    return ORD_SENSOR;
            default: return CLASS_WRITE | 8'($urandom_range(0, 63));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < MAX_LINES)
            $display("mismatch on %s at word %0d: got %0h, want %0h",
                     what, events_sent, got, want);
        mismatch_count++;
    endtask

    // valid stays high from one word to the next unless a gap is drawn
    task automatic send_word(input t_in_item w);
        int gap;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= w;
        do @(posedge i_clk); while (o_in_stall);
        bus_reply_q.push_back(predict_reply(w));
        events_sent++;
    endtask

    // reply checker and receive-side stall bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (bus_reply_q.size() == 0) begin
                report_mismatch("unexpected reply", o_out_item, 0);
            end else begin
                want_reply = bus_reply_q.pop_front();
                if (o_out_item.tx_valid !== want_reply.tx_valid)
                    report_mismatch("tx_valid", o_out_item.tx_valid, want_reply.tx_valid);
                if (o_out_item.tx_byte !== want_reply.tx_byte)
                    report_mismatch("tx_byte", o_out_item.tx_byte, want_reply.tx_byte);
                if (o_out_item.cmd_valid !== want_reply.cmd_valid)
                    report_mismatch("cmd_valid", o_out_item.cmd_valid, want_reply.cmd_valid);
                if (o_out_item.cmd_kind !== want_reply.cmd_kind)
                    report_mismatch("cmd_kind", o_out_item.cmd_kind, want_reply.cmd_kind);
                if (o_out_item.cmd_data !== want_reply.cmd_data)
                    report_mismatch("cmd_data", o_out_item.cmd_data, want_reply.cmd_data);
            end
        end
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(0, 7);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("i2c_slave_command_register_map_core_test failed");
            $finish;
        end
    end

    task automatic test_write_commands();
        send_word(pack_event(OP_BYTE_RX, ORD_POWER, 3'd0, 1'b0, 3'd0));
        send_word(pack_event(OP_BYTE_RX, 8'hFF, 3'd7, 1'b1, 3'd7));
        send_word(pack_event(OP_BYTE_RX, ORD_SENSOR, 3'd0, 1'b0, 3'd0));
        send_word(pack_event(OP_BYTE_RX, 8'h00, 3'd0, 1'b0, 3'd0));
        // unknown write order swallows its data byte
        send_word(pack_event(OP_BYTE_RX, 8'h7F, 3'd0, 1'b0, 3'd0));
        send_word(pack_event(OP_BYTE_RX, 8'h5A, 3'd0, 1'b0, 3'd0));
        send_word(pack_event(OP_ADDR_WR, 8'hFF, 3'd7, 1'b1, 3'd7));
        send_word(pack_event(OP_OTHER, 8'hFF, 3'd7, 1'b1, 3'd7));
    endtask

    task automatic test_button_read();
        send_word(pack_event(OP_SET_BUTTON, 8'hFF, 3'd0, 1'b0, 3'd0));
        send_word(pack_event(OP_BYTE_RX, ORD_BUTTON, 3'd0, 1'b0, 3'd0));
        send_word(pack_event(OP_ADDR_RD, 8'h00, 3'd0, 1'b0, 3'd0));
        send_word(pack_event(OP_BYTE_ACK, 8'h00, 3'd0, 1'b0, 3'd0));
    endtask

    task automatic test_sensor_read();
        send_word(pack_event(OP_LOAD, 8'hA5, 3'd3, 1'b1, 3'd3));
        send_word(pack_event(OP_LOAD, 8'h11, 3'd7, 1'b1, 3'd0));  // no such buffer
        send_word(pack_event(OP_LOAD, 8'h22, 3'd3, 1'b1, 3'd7));  // offset out of range
        send_word(pack_event(OP_SET_BANK, 8'h00, 3'd3, 1'b1, 3'd0));
        send_word(pack_event(OP_BYTE_RX, ORD_PWR, 3'd0, 1'b0, 3'd0));
        send_word(pack_event(OP_ADDR_RD, 8'h00, 3'd0, 1'b0, 3'd0));
        repeat (4) send_word(pack_event(OP_BYTE_ACK, 8'h00, 3'd0, 1'b0, 3'd0));
    endtask

    task automatic test_unknown_read();
        send_word(pack_event(OP_BYTE_RX, 8'hC3, 3'd0, 1'b0, 3'd0));
        send_word(pack_event(OP_ADDR_RD, 8'h00, 3'd0, 1'b0, 3'd0));
        send_word(pack_event(OP_BYTE_RX, CLASS_READ, 3'd0, 1'b0, 3'd0));
        send_word(pack_event(OP_ADDR_RD, 8'h00, 3'd0, 1'b0, 3'd0));
    endtask

    // mostly well-formed transactions with random content, some noise
    task automatic run_bus_traffic(input int n_words);
        int start;
        int pick;
        int n;
        t_in_item w;
        logic [2:0] id;
        logic bk;
        start = events_sent;
        while (events_sent - start < n_words) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                w = rand_event(OP_BYTE_RX);
                w.byte_in = pick_read_order();
                send_word(w);
                send_word(rand_event(OP_ADDR_RD));
                n = $urandom_range(0, 9);
                repeat (n) send_word(rand_event(OP_BYTE_ACK));
            end else if (pick < 55) begin
                w = rand_event(OP_BYTE_RX);
                w.byte_in = pick_write_order();
                send_word(w);
                send_word(rand_event(OP_BYTE_RX));
            end else if (pick < 75) begin
                if ($urandom_range(0, 1) == 0) begin
                    id = 3'($urandom_range(0, 5));
                    bk = 1'($urandom_range(0, 1));
                    for (int k = 0; k < BUF_LEN; k++) begin
                        w = rand_event(OP_LOAD);
                        w.buffer_id = id;
                        w.bank = bk;
                        w.offset = 3'(k);
                        send_word(w);
                    end
                end else begin
                    n = $urandom_range(1, 4);
                    repeat (n) send_word(rand_event(OP_LOAD));
                end
            end else if (pick < 83) begin
                send_word(rand_event(OP_SET_BANK));
            end else if (pick < 88) begin
                send_word(rand_event(OP_SET_BUTTON));
            end else begin
                send_word(rand_event(t_opcode'($urandom_range(0, 7))));
            end
        end
    endtask

    task automatic test_random_traffic();
        idling_on = 1'b1;
        run_bus_traffic(1500);
    endtask

    task automatic test_back_to_back();
        idling_on = 1'b0;
        run_bus_traffic(250);
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_item      = '0;
        i_out_stall    = 1'b0;
        idling_on      = 1'b1;
        mismatch_count = 0;
        events_sent    = 0;
        cycle_count    = 0;
        stall_left     = 0;
        order_q        = 8'h00;
        button_q       = 8'h00;
        act_buf        = NO_BUFFER;
        act_bank       = 1'b0;
        rd_ptr         = '0;
        for (int i = 0; i < NUM_BUF; i++) begin
            bank_sel[i] = 1'b0;
            for (int j = 0; j < 2; j++)
                for (int k = 0; k < BUF_LEN; k++)
                    sensor_mem[i][j][k] = 8'h00;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_write_commands();
        test_button_read();
        test_sensor_read();
        test_unknown_read();
        test_random_traffic();
        test_back_to_back();

        i_in_valid <= 1'b0;
        while (bus_reply_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("i2c_slave_command_register_map_core_test passed");
        end else begin
            $display("i2c_slave_command_register_map_core_test failed");
        end
        $finish;
    end

endmodule
